// ===== rtl/hcd_pkg.sv =====
// ----------------------------------------------------------------------------
// hcd_pkg
// Shared types, character codes and decode helpers for the chunked decoder.
// ----------------------------------------------------------------------------
package hcd_pkg;

  // Parser modes.
  localparam logic [2:0] MODE_BOUNDARY = 3'd0;
  localparam logic [2:0] MODE_LEAD     = 3'd1;
  localparam logic [2:0] MODE_HEX      = 3'd2;
  localparam logic [2:0] MODE_TAIL     = 3'd3;
  localparam logic [2:0] MODE_DATA     = 3'd4;

  // Character codes.
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_VT    = 8'h0B;
  localparam logic [7:0] CHAR_FF    = 8'h0C;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  // Reset value of the size line limit.
  localparam logic [5:0] MAX_HDR_RESET = 6'd15;

  // One result beat.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       data_valid;
    logic       error;
  } hcd_result_t;

  // Hex digit decode: bit 4 flags a digit, bits 3:0 hold its value.
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

  // Blanks skipped ahead of the digits.
  function automatic logic is_blank(input logic [7:0] c);
    return (c == CHAR_SPACE) || (c == CHAR_TAB) || (c == CHAR_VT) ||
           (c == CHAR_FF) || (c == CHAR_CR);
  endfunction

endpackage

// ===== rtl/http_chunked_decoder.sv =====
// ----------------------------------------------------------------------------
// http_chunked_decoder
// Strips chunk framing from an HTTP chunked body, one byte per beat.
// ----------------------------------------------------------------------------
//   Channel  Direction  Handshake        Payload
//   in       input      in_valid/stall   in_byte
//   out      output     out_valid/stall  out_data_byte, out_data_valid, out_error
//   cfg      input      cfg_valid/ready  cfg_max_header_len
//
// Every input beat gives exactly one result beat. The result passes through the
// input register and then the result register before it is offered.
// One beat per cycle is sustained while out_stall is low; the parser step between
// the input register and the result register sets that rate.
// A result held by out_stall keeps the input register loaded, so in_stall rises
// only when both registers are full. Reset is synchronous and clears the parser
// state and both valid flags.
// ----------------------------------------------------------------------------
module http_chunked_decoder #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_data_byte,
  output logic       out_data_valid,
  output logic       out_error,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [5:0] cfg_max_header_len
);

  logic [5:0]           max_hdr_r;
  logic                 in_full_r;
  logic [7:0]           in_byte_r;
  logic                 out_full_r;
  hcd_pkg::hcd_result_t out_res_r;
  hcd_pkg::hcd_result_t step_res;
  logic                 out_free;
  logic                 advance;

  assign out_free  = !out_full_r || !out_stall;
  assign advance   = in_full_r && out_free;
  assign in_stall  = in_full_r && !out_free;
  assign cfg_ready = 1'b1;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_hdr_r <= hcd_pkg::MAX_HDR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_hdr_r <= cfg_max_header_len;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_full_r <= 1'b0;
    end else if (!in_stall) begin
      in_full_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_byte_r <= in_byte;
    end
  end

  hcd_parser #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_parser (
    .clk            (clk),
    .rst_n          (rst_n),
    .step_en        (advance),
    .step_byte      (in_byte_r),
    .max_header_len (max_hdr_r),
    .step_result    (step_res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_full_r <= 1'b0;
    end else if (out_free) begin
      out_full_r <= in_full_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= step_res;
    end
  end

  assign out_valid      = out_full_r;
  assign out_data_byte  = out_res_r.data_byte;
  assign out_data_valid = out_res_r.data_valid;
  assign out_error      = out_res_r.error;

endmodule

// ===== rtl/hcd_parser.sv =====
// ----------------------------------------------------------------------------
// hcd_parser
// Parser state and the per-byte step: payload pass, size line decode, error.
// ----------------------------------------------------------------------------
module hcd_parser #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step_en,
  input  logic [7:0]           step_byte,
  input  logic [5:0]           max_header_len,
  output hcd_pkg::hcd_result_t step_result
);

  localparam logic [COUNT_WIDTH-1:0] LEFT_ONE = {{(COUNT_WIDTH-1){1'b0}}, 1'b1};

  logic [2:0]             mode_r, mode_nxt;
  logic [COUNT_WIDTH-1:0] left_r, left_nxt;
  logic [5:0]             hcnt_r, hcnt_nxt;
  logic                   err_r, err_nxt;

  // Inputs to the size line step, after the boundary opens a new line.
  logic                   sc_en;
  logic [2:0]             sc_mode;
  logic [COUNT_WIDTH-1:0] sc_left;
  logic [5:0]             sc_hcnt;
  logic [2:0]             sc_mode_new;
  logic [4:0]             hex;
  logic [COUNT_WIDTH-1:0] left_dec;
  logic [COUNT_WIDTH-1:0] left_acc;

  assign hex      = hcd_pkg::hex_decode(step_byte);
  assign left_dec = (left_r != '0) ? left_r - LEFT_ONE : left_r;

  // Shift in one digit, saturating when the top nibble is already in use.
  always_comb begin
    if (sc_left[COUNT_WIDTH-1 -: 4] != 4'd0) begin
      left_acc = '1;
    end else begin
      left_acc = {sc_left[COUNT_WIDTH-5:0], hex[3:0]};
    end
  end

  // Mode change of a size line character that is not LF.
  always_comb begin
    sc_mode_new = sc_mode;
    if (sc_mode == hcd_pkg::MODE_LEAD) begin
      if (hex[4]) begin
        sc_mode_new = hcd_pkg::MODE_HEX;
      end else if (!hcd_pkg::is_blank(step_byte)) begin
        sc_mode_new = hcd_pkg::MODE_TAIL;
      end
    end else if (sc_mode == hcd_pkg::MODE_HEX && !hex[4]) begin
      sc_mode_new = hcd_pkg::MODE_TAIL;
    end
  end

  // Per-byte step.
  always_comb begin
    mode_nxt = mode_r;
    left_nxt = left_r;
    hcnt_nxt = hcnt_r;
    err_nxt  = err_r;
    sc_en    = 1'b0;
    sc_mode  = mode_r;
    sc_left  = left_r;
    sc_hcnt  = hcnt_r;
    step_result.data_byte  = 8'd0;
    step_result.data_valid = 1'b0;

    if (!err_r) begin
      unique case (mode_r)
        hcd_pkg::MODE_DATA: begin
          step_result.data_byte  = step_byte;
          step_result.data_valid = 1'b1;
          left_nxt = left_dec;
          if (left_dec == '0) begin
            mode_nxt = hcd_pkg::MODE_BOUNDARY;
          end
        end
        hcd_pkg::MODE_LEAD, hcd_pkg::MODE_HEX, hcd_pkg::MODE_TAIL: begin
          sc_en = 1'b1;
        end
        default: begin
          mode_nxt = hcd_pkg::MODE_BOUNDARY;
          if (step_byte != hcd_pkg::CHAR_CR && step_byte != hcd_pkg::CHAR_LF) begin
            sc_en   = 1'b1;
            sc_mode = hcd_pkg::MODE_LEAD;
            sc_left = '0;
            sc_hcnt = 6'd0;
          end
        end
      endcase
    end

    // Size line character.
    if (sc_en) begin
      mode_nxt = sc_mode;
      left_nxt = sc_left;
      hcnt_nxt = sc_hcnt;
      if (step_byte == hcd_pkg::CHAR_LF) begin
        hcnt_nxt = 6'd0;
        mode_nxt = (sc_left != '0) ? hcd_pkg::MODE_DATA : hcd_pkg::MODE_BOUNDARY;
      end else if (sc_hcnt >= max_header_len) begin
        err_nxt = 1'b1;
      end else begin
        hcnt_nxt = sc_hcnt + 6'd1;
        mode_nxt = sc_mode_new;
        if (sc_mode_new == hcd_pkg::MODE_HEX && hex[4]) begin
          left_nxt = left_acc;
        end
      end
    end

    step_result.error = err_nxt;
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= hcd_pkg::MODE_BOUNDARY;
      left_r <= '0;
      hcnt_r <= 6'd0;
      err_r  <= 1'b0;
    end else if (step_en) begin
      mode_r <= mode_nxt;
      left_r <= left_nxt;
      hcnt_r <= hcnt_nxt;
      err_r  <= err_nxt;
    end
  end

endmodule

// ===== rtl/hcd_checker.sv =====
// ----------------------------------------------------------------------------
// hcd_checker
// Port-level checks of the chunked decoder, bound to the top level.
// ----------------------------------------------------------------------------
module hcd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_data_byte,
  input logic       out_data_valid,
  input logic       out_error
);

  logic       seen_err_r;
  logic [1:0] pend_r;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  // Track a delivered error and the beats in flight.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_err_r <= 1'b0;
      pend_r     <= 2'd0;
    end else begin
      if (out_acc && out_error) begin
        seen_err_r <= 1'b1;
      end
      pend_r <= pend_r + {1'b0, in_acc} - {1'b0, out_acc};
    end
  end

  // Once an error has been delivered, every later result carries it.
  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && seen_err_r |-> out_error)
    else $error("error flag dropped after it was reported");

  // A result with the error flag never carries payload.
  a_err_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error |-> !out_data_valid)
    else $error("payload beat reported together with error");

  // Non-payload results carry a zero byte.
  a_zero_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data_valid |-> out_data_byte == 8'd0)
    else $error("non-payload result has a nonzero byte");

  // No result appears without an input beat behind it, and at most two wait.
  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid || pend_r != 2'd0) && pend_r != 2'd3)
    else $error("result count does not match input beats");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data_byte) &&
      $stable(out_data_valid) && $stable(out_error))
    else $error("stalled result changed");

endmodule

bind http_chunked_decoder hcd_checker u_hcd_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_data_byte  (out_data_byte),
  .out_data_valid (out_data_valid),
  .out_error      (out_error)
);
